>>> hw/rtl/isqrt_pkg.sv
// Shared widths and limits for the pipelined integer square root.
package isqrt_pkg;

   localparam int VALUE_W     = 64;
   localparam int ROOT_OUT_W  = 32;
   localparam int MIN_OPER_W  = 8;
   localparam int MAX_OPER_W  = 64;

endpackage

>>> hw/rtl/isqrt_if.sv
// Valid/ready channel interfaces for operand and result transactions.
interface isqrt_req_if
   import isqrt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface isqrt_rsp_if
   import isqrt_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [ROOT_OUT_W-1:0] root;
   logic                  perfect_square;

   modport source (output valid, output root, output perfect_square, input ready);
   modport sink   (input valid, input root, input perfect_square, output ready);
endinterface

>>> hw/rtl/integer_square_root_top.sv
// Integer square root: pipelined top level with one stage per root bit.
//
// Usage:
//   req_ch carries one 64-bit unsigned operand per transaction; only the low
//   OPERAND_WIDTH bits (clamped to 8..64) are used.
//   rsp_ch returns one transaction per operand: root = floor(sqrt(value))
//   and perfect_square = 1 when root * root equals the operand.
//   Results leave in the order the operands arrived.
// Timing:
//   Each stage resolves one root bit with one trial subtract and registers
//   the result. A new operand is accepted every cycle unless a stalled
//   rsp_ch receiver has backed up the pipeline to its first stage.
// Flow control:
//   Each stage holds its own valid bit and loads when it is empty or the
//   next stage moves on, so a stalled receiver fills the pipeline from the
//   back without loss; bubbles are squeezed out while stalled.
// Reset:
//   Synchronous reset clears every valid bit; no result is pending after it.
module integer_square_root_top
   import isqrt_pkg::*;
#(
   parameter int OPERAND_WIDTH = 64
) (
   input logic         clock,
   input logic         reset,
   isqrt_req_if.sink   req_ch,
   isqrt_rsp_if.source rsp_ch
);

   localparam int EFF_W  = (OPERAND_WIDTH < MIN_OPER_W) ? MIN_OPER_W :
                           (OPERAND_WIDTH > MAX_OPER_W) ? MAX_OPER_W : OPERAND_WIDTH;
   localparam int ROOT_W = (EFF_W + 1) / 2;
   localparam int PAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   logic              valid [0:ROOT_W];
   logic              ready [0:ROOT_W];
   logic [PAD_W-1:0]  rad   [0:ROOT_W-1];
   logic [REM_W-1:0]  rem   [0:ROOT_W];
   logic [ROOT_W-1:0] root  [0:ROOT_W];

   assign valid[0]     = req_ch.valid;
   assign req_ch.ready = ready[0];
   assign rad[0]       = PAD_W'(req_ch.value[EFF_W-1:0]);
   assign rem[0]       = '0;
   assign root[0]      = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      if (k < ROOT_W - 1) begin : g_mid
         isqrt_stage #(
            .ROOT_W (ROOT_W),
            .STEP   (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_rad    (rad[k]),
            .in_rem    (rem[k]),
            .in_root   (root[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_rad   (rad[k+1]),
            .out_rem   (rem[k+1]),
            .out_root  (root[k+1])
         );
      end else begin : g_last
         isqrt_stage #(
            .ROOT_W (ROOT_W),
            .STEP   (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_rad    (rad[k]),
            .in_rem    (rem[k]),
            .in_root   (root[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_rad   (),
            .out_rem   (rem[k+1]),
            .out_root  (root[k+1])
         );
      end
   end

   assign ready[ROOT_W]         = rsp_ch.ready;
   assign rsp_ch.valid          = valid[ROOT_W];
   assign rsp_ch.root           = ROOT_OUT_W'(root[ROOT_W]);
   assign rsp_ch.perfect_square = (rem[ROOT_W] == '0);

endmodule

>>> hw/rtl/isqrt_stage.sv
// One root bit of the square root pipeline: trial subtract and register.
module isqrt_stage
   import isqrt_pkg::*;
#(
   parameter int ROOT_W = 32,
   parameter int STEP   = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [ROOT_W+1:0]     in_rem,
   input  logic [ROOT_W-1:0]     in_root,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [2*ROOT_W-1:0]   out_rad,
   output logic [ROOT_W+1:0]     out_rem,
   output logic [ROOT_W-1:0]     out_root
);

   localparam int PAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int WK_W   = REM_W + 2;
   localparam int BIT_LO = 2 * (ROOT_W - 1 - STEP);

   logic              valid_ff;
   logic [PAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;

   logic [WK_W-1:0]   shifted;
   logic [WK_W-1:0]   trial;
   logic [WK_W-1:0]   diff;
   logic              take;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted = {in_rem, in_rad[BIT_LO +: 2]};
      trial   = WK_W'({in_root, 2'b01});
      diff    = shifted - trial;
      take    = shifted >= trial;
      rem_in  = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      root_in = {in_root[ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rad_ff  <= in_rad;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

>>> sim/integer_square_root_top_tb.sv
// Self-checking testbench for the pipelined integer square root top level.
module integer_square_root_top_tb;
   import isqrt_pkg::*;

   localparam int SQRT_OPER_W  = 64;
   localparam int RANDOM_ITEMS = 450;
   localparam int CALM_ITEMS   = 60;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [ROOT_OUT_W-1:0] root;
      logic                  perfect_square;
   } sqrt_result_type;

   class sqrt_scoreboard;
      sqrt_result_type pending_roots[$];
      int unsigned     errors;

      function sqrt_result_type floor_root(logic [VALUE_W-1:0] value);
         int unsigned        width;
         int                 top_bit;
         logic [VALUE_W-1:0] operand;
         logic [VALUE_W-1:0] root;
         logic [VALUE_W-1:0] trial;
         sqrt_result_type    res;
         width = (SQRT_OPER_W < MIN_OPER_W) ? MIN_OPER_W :
                 (SQRT_OPER_W > MAX_OPER_W) ? MAX_OPER_W : SQRT_OPER_W;
         operand = value & ({VALUE_W{1'b1}} >> (VALUE_W - width));
         top_bit = (width + 1) / 2 - 1;
         root = '0;
         for (int b = top_bit; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= operand) begin
               root = trial;
            end
         end
         res.root           = root[ROOT_OUT_W-1:0];
         res.perfect_square = (root * root == operand);
         return res;
      endfunction

      function void note_operand(logic [VALUE_W-1:0] value);
         pending_roots.push_back(floor_root(value));
      endfunction

      function void check_result(logic [ROOT_OUT_W-1:0] root, logic perfect_square);
         sqrt_result_type exp_res;
         if (pending_roots.size() == 0) begin
            $error("unexpected transaction: root %0h perfect_square %0b", root,
                   perfect_square);
            errors++;
         end else begin
            exp_res = pending_roots.pop_front();
            if (root !== exp_res.root) begin
               $error("root mismatch: expected %0h, actual %0h", exp_res.root, root);
               errors++;
            end
            if (perfect_square !== exp_res.perfect_square) begin
               $error("perfect_square mismatch: expected %0b, actual %0b",
                      exp_res.perfect_square, perfect_square);
               errors++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_roots.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   isqrt_req_if req_bus ();
   isqrt_rsp_if rsp_bus ();

   sqrt_scoreboard sqrt_sb = new();

   int unsigned req_gap_odds;
   int unsigned rsp_stall_odds;

   logic [VALUE_W-1:0] corner_operands [22] = '{
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002,
      64'h0000_0000_0000_0003, 64'h0000_0000_0000_0004, 64'h0000_0000_0000_0008,
      64'h0000_0000_0000_0009, 64'h0000_0000_0000_000F, 64'h0000_0000_0000_0010,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
      64'hFFFF_FFFE_0000_0002, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
      64'h3FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0001,
      64'h0000_0000_0000_0024
   };

   integer_square_root_top #(
      .OPERAND_WIDTH(SQRT_OPER_W)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [VALUE_W-1:0] random_operand();
      logic [VALUE_W-1:0] k;
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: begin
            k = {32'd0, $urandom};
            v = k * k;
         end
         2: begin
            k = {32'd0, $urandom};
            v = ($urandom_range(0, 1) == 1) ? k * k + 1 : k * k - 1;
         end
         3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         4: v = ~({32'd0, $urandom} >> $urandom_range(0, 31));
         default: begin
            k = {48'd0, 16'($urandom_range(0, 65535))};
            v = k * k + 64'($urandom_range(0, 16)) - 64'd8;
         end
      endcase
      return v;
   endfunction

   task automatic send_operand(input logic [VALUE_W-1:0] value);
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      sqrt_sb.note_operand(value);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sqrt_sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      req_gap_odds   = 0;
      rsp_stall_odds = 0;
      reset          = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (corner_operands[i]) begin
         send_operand(corner_operands[i]);
      end
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            req_gap_odds   = (n >= RANDOM_ITEMS - CALM_ITEMS) ? 0 : $urandom_range(0, 2) * 2;
            rsp_stall_odds = (n >= RANDOM_ITEMS - CALM_ITEMS) ? 0 : $urandom_range(0, 2) * 2;
         end
         if (n == RANDOM_ITEMS / 2) begin
            drain_results();
         end
         send_operand(random_operand());
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sqrt_sb.errors == 0 && sqrt_sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 2)) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sqrt_sb.check_result(rsp_bus.root, rsp_bus.perfect_square);
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
